### hw/rtl/epaper_pixel_update_top_macros.svh
// ----------------------------------------------------------------------------
// epaper_pixel_update_top_macros.svh
// Assertion macros used by epaper_pixel_update_top. Each macro samples on clk
// and is muted while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EPAPER_PIXEL_UPDATE_TOP_MACROS_SVH
`define EPAPER_PIXEL_UPDATE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define EPU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("epu: same-cycle check failed");
// Next-cycle implication.
`define EPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("epu: next-cycle check failed");
`else
`define EPU_ASSERT_NOW(label, ante, cons)
`define EPU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/epu_pkg.sv
// ----------------------------------------------------------------------------
// epu_pkg
// Types, codes and helper functions of the e-paper pixel update block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package epu_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 8;

  // Waveform mode codes
  localparam logic [MODE_W-1:0] WAVE_A2         = 3'd0;
  localparam logic [MODE_W-1:0] WAVE_DU         = 3'd1;
  localparam logic [MODE_W-1:0] WAVE_GL16       = 3'd2;
  localparam logic [MODE_W-1:0] WAVE_REAGL      = 3'd3;
  localparam logic [MODE_W-1:0] WAVE_GC16       = 3'd4;
  localparam logic [MODE_W-1:0] WAVE_GC16_FLASH = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WAVEFORM_MODE  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISUSE_STRIPES = 4'd1;

  // Ghost residual: floor(m * 8 / 100) == (m * 82) >> 10 for m <= 255
  localparam logic [6:0] GHOST_RECIP   = 7'd82;
  localparam int unsigned GHOST_SHIFT  = 10;
  localparam int unsigned GHOST_PROD_W = 15;
  localparam int unsigned GHOST_Q_W    = 5;

  typedef struct packed {
    logic [PIX_W-1:0] source_value;
    logic [PIX_W-1:0] previous_value;
    logic [POS_W-1:0] pixel_x;
    logic [POS_W-1:0] pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] panel_value;
  } out_word_t;

  typedef struct packed {
    logic [MODE_W-1:0] waveform_mode;
    logic              misuse_stripes;
  } cfg_state_t;

  // 16-level quantizer: ((v*15+127)/255)*17, divide by 255 done as a split
  // at 256 plus one correction step.
  function automatic logic [PIX_W-1:0] level16(input logic [PIX_W-1:0] v);
    logic [11:0] n;
    logic [3:0]  t;
    logic [8:0]  rem;
    logic [3:0]  q;
    n   = 12'(v) * 12'd15 + 12'd127;
    t   = n[11:8];
    rem = 9'(n[7:0]) + 9'(t);
    q   = (rem >= 9'd255) ? t + 4'd1 : t;
    return {q, q};
  endfunction

endpackage

`default_nettype wire

### hw/rtl/epu_if.sv
// ----------------------------------------------------------------------------
// epu_if
// Valid/ready channels of the pixel update block: input, result, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface epu_in_if;
  logic             valid;
  logic             ready;
  epu_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface epu_out_if;
  logic               valid;
  logic               ready;
  epu_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface epu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [epu_pkg::CFG_IDX_W-1:0]     index;
  logic [epu_pkg::CFG_DATA_W-1:0]    wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/epu_target.sv
// ----------------------------------------------------------------------------
// epu_target
// Target level of one pixel: threshold or 16-level quantize, then stripes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epu_target (
  input  wire epu_pkg::in_word_t   word_i,
  input  wire epu_pkg::cfg_state_t cfg_i,
  output logic [epu_pkg::PIX_W-1:0] target_o,
  output logic                      flash_o
);
  import epu_pkg::*;

  logic             binary;
  logic [PIX_W-1:0] level;
  logic [2:0]       diag;
  logic             stripe;

  always_comb begin
    binary = (cfg_i.waveform_mode == WAVE_A2) || (cfg_i.waveform_mode == WAVE_DU);
    if (binary) begin
      level = word_i.source_value[PIX_W-1] ? 8'd255 : 8'd0;
    end else begin
      level = level16(word_i.source_value);
    end
    // only the low three bits of x+y matter
    diag     = word_i.pixel_x[2:0] + word_i.pixel_y[2:0];
    stripe   = cfg_i.misuse_stripes && (diag[2:1] == 2'b00);
    target_o = stripe ? ~level : level;
    flash_o  = (cfg_i.waveform_mode == WAVE_GC16_FLASH);
  end

endmodule

`default_nettype wire

### hw/rtl/epaper_pixel_update_top.sv
// ----------------------------------------------------------------------------
// epaper_pixel_update_top
// New panel gray value per pixel during an e-paper refresh.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   takes one word per pixel: source byte, current panel value and
//           the pixel's absolute x,y. A word is taken when valid and ready
//           are both high at a rising edge of clk.
//   out_ch  returns one word per input word, in order: the new panel value.
//   cfg_ch  writes waveform_mode (index 0) and misuse_stripes (index 1);
//           other indexes are dropped. It is always ready. Write it only
//           while no pixel is in flight.
// Data path: a taken word moves through the target, residual magnitude
//   and final value registers; the final value register drives out_ch.
// Throughput: one pixel per clock while out_ch is ready; the three pipeline
//   registers (target, residual magnitude, final value) each hold one pixel,
//   and each stage advances on its own whenever the stage after it is free,
//   so a bubble closes up.
// Reset (rst_n low, synchronous): drop all words in flight, mode back to
//   GC16, stripes off.
// Receiver stall: words hold in place; in_ch keeps accepting until all
//   three stages are full, then deasserts ready. Nothing is lost or doubled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epaper_pixel_update_top (
  input  wire  clk,
  input  wire  rst_n,
  epu_in_if.sink    in_ch,
  epu_out_if.source out_ch,
  epu_cfg_if.sink   cfg_ch
);
  import epu_pkg::*;

  `include "epaper_pixel_update_top_macros.svh"

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_state_t cfg_r, cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_WAVEFORM_MODE:  cfg_nxt.waveform_mode  = cfg_ch.wdata[MODE_W-1:0];
        CFG_MISUSE_STRIPES: cfg_nxt.misuse_stripes = cfg_ch.wdata[0];
        default:            cfg_nxt = cfg_r;   // unknown register: drop
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.waveform_mode  <= WAVE_GC16;
      cfg_r.misuse_stripes <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage ready chain: a stage can load when it is empty or its word moves on
  // --------------------------------------------------------------------------
  logic s1_vld_r, s1_vld_nxt;
  logic s2_vld_r, s2_vld_nxt;
  logic s3_vld_r, s3_vld_nxt;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy      = !s3_vld_r || out_ch.ready;
  assign s2_rdy      = !s2_vld_r || s3_rdy;
  assign s1_rdy      = !s1_vld_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  // --------------------------------------------------------------------------
  // Stage 1: target level (threshold / quantize, stripes)
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] tgt_comb;
  logic             flash_comb;

  epu_target u_target (
    .word_i   (in_ch.data),
    .cfg_i    (cfg_r),
    .target_o (tgt_comb),
    .flash_o  (flash_comb)
  );

  logic [PIX_W-1:0] s1_target_r, s1_target_nxt;
  logic [PIX_W-1:0] s1_prev_r,   s1_prev_nxt;
  logic             s1_flash_r,  s1_flash_nxt;

  always_comb begin
    s1_vld_nxt    = s1_vld_r;
    s1_target_nxt = s1_target_r;
    s1_prev_nxt   = s1_prev_r;
    s1_flash_nxt  = s1_flash_r;
    if (s1_rdy) begin
      s1_vld_nxt    = in_ch.valid;
      s1_target_nxt = tgt_comb;
      s1_prev_nxt   = in_ch.data.previous_value;
      s1_flash_nxt  = flash_comb;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: signed difference prev - target, split into sign and magnitude
  // --------------------------------------------------------------------------
  logic [PIX_W:0]   diff;
  logic [PIX_W-1:0] s2_mag_r,    s2_mag_nxt;
  logic             s2_neg_r,    s2_neg_nxt;
  logic [PIX_W-1:0] s2_target_r, s2_target_nxt;
  logic             s2_flash_r,  s2_flash_nxt;

  always_comb begin
    diff          = {1'b0, s1_prev_r} - {1'b0, s1_target_r};
    s2_vld_nxt    = s2_vld_r;
    s2_mag_nxt    = s2_mag_r;
    s2_neg_nxt    = s2_neg_r;
    s2_target_nxt = s2_target_r;
    s2_flash_nxt  = s2_flash_r;
    if (s2_rdy) begin
      s2_vld_nxt    = s1_vld_r;
      s2_neg_nxt    = diff[PIX_W];
      s2_mag_nxt    = diff[PIX_W] ? PIX_W'(-diff) : diff[PIX_W-1:0];
      s2_target_nxt = s1_target_r;
      s2_flash_nxt  = s1_flash_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: target + residual trunc(diff*8/100) by reciprocal; flash: target
  // --------------------------------------------------------------------------
  logic [GHOST_PROD_W-1:0] ghost_prod;
  logic [GHOST_Q_W-1:0]    ghost_q;
  logic [PIX_W-1:0]        s3_value_r, s3_value_nxt;

  always_comb begin
    ghost_prod   = GHOST_PROD_W'(s2_mag_r) * GHOST_PROD_W'(GHOST_RECIP);
    ghost_q      = ghost_prod[GHOST_PROD_W-1:GHOST_SHIFT];
    s3_vld_nxt   = s3_vld_r;
    s3_value_nxt = s3_value_r;
    if (s3_rdy) begin
      s3_vld_nxt = s2_vld_r;
      if (s2_flash_r) begin
        s3_value_nxt = s2_target_r;
      end else if (s2_neg_r) begin
        s3_value_nxt = s2_target_r - PIX_W'(ghost_q);
      end else begin
        s3_value_nxt = s2_target_r + PIX_W'(ghost_q);
      end
    end
  end

  assign out_ch.valid            = s3_vld_r;
  assign out_ch.data.panel_value = s3_value_r;

  // --------------------------------------------------------------------------
  // Pipeline registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
      s3_vld_r <= s3_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_target_r <= s1_target_nxt;
    s1_prev_r   <= s1_prev_nxt;
    s1_flash_r  <= s1_flash_nxt;
    s2_mag_r    <= s2_mag_nxt;
    s2_neg_r    <= s2_neg_nxt;
    s2_target_r <= s2_target_nxt;
    s2_flash_r  <= s2_flash_nxt;
    s3_value_r  <= s3_value_nxt;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Input backpressure only when every stage holds a word.
  `EPU_ASSERT_NOW(a_full_when_blocked, !s1_rdy, s1_vld_r && s2_vld_r && s3_vld_r)
  // A stage 1 word that cannot advance holds its target.
  `EPU_ASSERT_NEXT(a_s1_hold, s1_vld_r && !s2_rdy, s1_vld_r && $stable(s1_target_r))
  // A stage 2 word that cannot advance holds its residual magnitude.
  `EPU_ASSERT_NEXT(a_s2_hold, s2_vld_r && !s3_rdy, s2_vld_r && $stable(s2_mag_r))
  // Ghost residual never exceeds 255*8/100.
  `EPU_ASSERT_NOW(a_ghost_bound, s2_vld_r, ghost_q <= 5'd20)

endmodule

`default_nettype wire
